/* design/chrt_pkg.sv */
package chrt_pkg;

	// Default table depth in ring points
	localparam int MAX_POINTS_DEF = 64;

	// Field widths
	localparam int POS_W  = 16;
	localparam int NODE_W = 8;
	localparam int TOT_W  = 7;

	// Action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		CS_IDLE,
		CS_EXEC
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch request and compare vector
		logic commit;   // update table, load result
	} chrt_cmd_t;

endpackage

/* design/chrt_ctrl.sv */
module chrt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output chrt_pkg::chrt_cmd_t   cmd
);

	chrt_pkg::ctrl_state_t state_q, state_nx;
	logic                  rsp_valid_q;
	logic                  rsp_free;

	// result slot is free when empty or being taken this cycle
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chrt_pkg::CS_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			chrt_pkg::CS_IDLE: begin
				if (req_valid) begin
					state_nx = chrt_pkg::CS_EXEC;
				end
			end
			chrt_pkg::CS_EXEC: begin
				if (rsp_free) begin
					state_nx = chrt_pkg::CS_IDLE;
				end
			end
			default: state_nx = chrt_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			chrt_pkg::CS_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			chrt_pkg::CS_EXEC: begin
				cmd.commit = rsp_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* design/chrt_dpath.sv */
module chrt_dpath #(
	parameter int MAX_POINTS = chrt_pkg::MAX_POINTS_DEF,
	parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  chrt_pkg::chrt_cmd_t         cmd,
	input  logic                        action,
	input  logic [chrt_pkg::POS_W-1:0]  position,
	input  logic [chrt_pkg::NODE_W-1:0] node_id,
	input  logic                        is_virtual,
	output logic [1:0]                  status,
	output logic [chrt_pkg::NODE_W-1:0] owner_node,
	output logic [chrt_pkg::POS_W-1:0]  owner_position,
	output logic                        owner_virtual,
	output logic [CNT_W-1:0]            point_cnt,
	output logic [CNT_W-1:0]            real_cnt
);

	// sorted point cells
	logic [chrt_pkg::POS_W-1:0]  pos_q  [MAX_POINTS];
	logic [chrt_pkg::NODE_W-1:0] node_q [MAX_POINTS];
	logic                        virt_q [MAX_POINTS];
	logic [CNT_W-1:0]            count_q, real_q;

	// captured request
	logic                        act_s1;
	logic [chrt_pkg::POS_W-1:0]  pos_s1;
	logic [chrt_pkg::NODE_W-1:0] node_s1;
	logic                        virt_s1;
	logic [MAX_POINTS-1:0]       cmp_s1;

	logic [MAX_POINTS-1:0]       cmp_d;
	logic [MAX_POINTS-1:0]       ins_at, ins_shift;
	logic [MAX_POINTS-1:0]       first_hit;
	logic                        any_hit, full, empty;
	logic [chrt_pkg::POS_W-1:0]  sel_pos;
	logic [chrt_pkg::NODE_W-1:0] sel_node;
	logic                        sel_virt;

	assign full  = (count_q == CNT_W'(MAX_POINTS));
	assign empty = (count_q == '0);

	// per-cell compare: insert wants position above, lookup at or above
	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			cmp_d[i] = (count_q > CNT_W'(i)) &&
				((pos_q[i] > position) ||
				 ((action == chrt_pkg::ACT_LOOKUP) && (pos_q[i] == position)));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_s1  <= action;
			pos_s1  <= position;
			node_s1 <= node_id;
			virt_s1 <= is_virtual;
			cmp_s1  <= cmp_d;
		end
	end

	// table is sorted, so hits form a run from the slot upward;
	// cells at and above the slot shift up by one
	always_comb begin
		logic s_cur, s_prev;
		s_prev = 1'b0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			s_cur        = cmp_s1[i] || (count_q <= CNT_W'(i));
			ins_shift[i] = s_prev;
			ins_at[i]    = s_cur && !s_prev;
			first_hit[i] = cmp_s1[i] && !((i > 0) ? cmp_s1[(i > 0) ? i - 1 : 0] : 1'b0);
			s_prev       = s_cur;
		end
	end

	assign any_hit = |cmp_s1;

	// one-hot select; wrap to the lowest point when nothing hits
	always_comb begin
		sel_pos  = '0;
		sel_node = '0;
		sel_virt = 1'b0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			sel_pos  = sel_pos  | ({chrt_pkg::POS_W{first_hit[i]}} & pos_q[i]);
			sel_node = sel_node | ({chrt_pkg::NODE_W{first_hit[i]}} & node_q[i]);
			sel_virt = sel_virt | (first_hit[i] & virt_q[i]);
		end
		if (!any_hit) begin
			sel_pos  = pos_q[0];
			sel_node = node_q[0];
			sel_virt = virt_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (act_s1 == chrt_pkg::ACT_INSERT) && !full) begin
			for (int i = 0; i < MAX_POINTS; i++) begin
				if (ins_shift[i]) begin
					pos_q[i]  <= pos_q[(i > 0) ? i - 1 : 0];
					node_q[i] <= node_q[(i > 0) ? i - 1 : 0];
					virt_q[i] <= virt_q[(i > 0) ? i - 1 : 0];
				end else if (ins_at[i]) begin
					pos_q[i]  <= pos_s1;
					node_q[i] <= node_s1;
					virt_q[i] <= virt_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			real_q  <= '0;
		end else if (cmd.commit && (act_s1 == chrt_pkg::ACT_INSERT) && !full) begin
			count_q <= count_q + CNT_W'(1);
			if (!virt_s1) begin
				real_q <= real_q + CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status         <= chrt_pkg::STAT_OK;
			owner_node     <= '0;
			owner_position <= '0;
			owner_virtual  <= 1'b0;
			if (act_s1 == chrt_pkg::ACT_INSERT) begin
				if (full) begin
					status <= chrt_pkg::STAT_FULL;
				end
			end else if (empty) begin
				status <= chrt_pkg::STAT_EMPTY;
			end else begin
				owner_node     <= sel_node;
				owner_position <= sel_pos;
				owner_virtual  <= sel_virt;
			end
		end
	end

	assign point_cnt = count_q;
	assign real_cnt  = real_q;

endmodule

/* design/consistent_hash_ring_table.sv */
// Consistent hash ring point table. Holds up to MAX_POINTS ring points kept
// sorted by position; each point has a 16-bit position, an 8-bit owner node
// and a virtual (replica) flag. action 0 inserts a point after any points of
// equal position, action 1 looks up the first point at or above the given
// position, wrapping to the lowest point. Every request transaction yields
// exactly one response transaction carrying status (ok / lookup on empty /
// insert into full), the found point for lookups (zeros otherwise) and the
// point and real-node counts after the request. One request is executed at
// a time; a new request is not accepted until the last one has committed.
// The capture step compares the request position against every table cell
// in parallel and registers the hit vector; the commit step shifts the cells
// at and above the slot up by one and writes the new point (insert), or picks
// the first hit cell (lookup), loading the response register. While a
// response is held by stall, one more request can still be accepted; it
// waits in the commit step until the held response is taken, and the request
// side stalls meanwhile. The table needs no clearing after reset; only points
// below the count are ever read.
module consistent_hash_ring_table #(
	parameter int MAX_POINTS = chrt_pkg::MAX_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        action,
	input  logic [chrt_pkg::POS_W-1:0]  position,
	input  logic [chrt_pkg::NODE_W-1:0] node_id,
	input  logic                        is_virtual,
	// response channel
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [1:0]                  status,
	output logic [chrt_pkg::NODE_W-1:0] owner_node,
	output logic [chrt_pkg::POS_W-1:0]  owner_position,
	output logic                        owner_virtual,
	output logic [chrt_pkg::TOT_W-1:0]  point_total,
	output logic [chrt_pkg::TOT_W-1:0]  real_total
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	chrt_pkg::chrt_cmd_t cmd;
	logic [CNT_W-1:0]    point_cnt, real_cnt;

	chrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	chrt_dpath #(
		.MAX_POINTS (MAX_POINTS),
		.CNT_W      (CNT_W)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.action         (action),
		.position       (position),
		.node_id        (node_id),
		.is_virtual     (is_virtual),
		.status         (status),
		.owner_node     (owner_node),
		.owner_position (owner_position),
		.owner_virtual  (owner_virtual),
		.point_cnt      (point_cnt),
		.real_cnt       (real_cnt)
	);

	// counts change only on commit, which waits for a free response slot,
	// so they stay matched to the response being presented
	assign point_total = chrt_pkg::TOT_W'(point_cnt);
	assign real_total  = chrt_pkg::TOT_W'(real_cnt);

	// one request in flight: an accept is followed by stall
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while another in flight");

	// table never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		point_cnt <= CNT_W'(MAX_POINTS))
		else $error("point count beyond table depth");

	// real points are a subset of all points
	a_real_bound: assert property (@(posedge clk) disable iff (!arst_n)
		real_cnt <= point_cnt)
		else $error("real count above point count");

	// a commit only happens from a captured request, never two in a row
	a_commit_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit)
		else $error("back to back commits");

endmodule
